// File: rtl/core/apph_pkg.sv
// ----------------------------------------------------------------------------
// apph_pkg
// shared types, codes and the packet type lookup for the header parser
// ----------------------------------------------------------------------------
package apph_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       payload_valid;
      logic [6:0] payload_byte;
      logic       packet_done;
      logic [7:0] from_node;
      logic [7:0] to_node;
      logic [7:0] next_talker;
      logic [3:0] packet_type;
      logic       error_valid;
      logic [3:0] error_code;
   } rsp_type;

   typedef enum logic {
      CSR_NODE_BOUND  = 1'b0,
      CSR_FIELD_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic          valid;
      csr_index_type index;
      logic [7:0]    data;
   } csr_wr_type;

   typedef enum logic [2:0] {
      CLS_SOH   = 3'd0,
      CLS_DIGIT = 3'd1,
      CLS_ALPHA = 3'd2,
      CLS_EQUAL = 3'd3,
      CLS_EOS   = 3'd4,
      CLS_JUNK  = 3'd5,
      CLS_WS    = 3'd6
   } cls_type;

   typedef enum logic [3:0] {
      ST_LISTEN  = 4'd0,
      ST_START   = 4'd1,
      ST_FROM    = 4'd2,
      ST_ENDFROM = 4'd3,
      ST_TO      = 4'd4,
      ST_ENDTO   = 4'd5,
      ST_NEXT    = 4'd6,
      ST_ENDNEXT = 4'd7,
      ST_TYPE    = 4'd8,
      ST_VALUE   = 4'd9,
      ST_PAYLOAD = 4'd10
   } state_type;

   typedef enum logic [3:0] {
      ERR_OVERRUN   = 4'd0,
      ERR_TIMEOUT   = 4'd1,
      ERR_BAD_START = 4'd2,
      ERR_BAD_FROM  = 4'd3,
      ERR_BAD_TO    = 4'd4,
      ERR_BAD_NEXT  = 4'd5,
      ERR_BAD_TYPE  = 4'd6,
      ERR_BAD_VALUE = 4'd7,
      ERR_INV_FROM  = 4'd8,
      ERR_INV_TO    = 4'd9,
      ERR_INV_NEXT  = 4'd10,
      ERR_INV_TYPE  = 4'd11
   } err_code_type;

   localparam logic [3:0] PKT_INVALID = 4'd0;
   localparam logic [3:0] PKT_TALK    = 4'd1;
   localparam logic [3:0] PKT_DATA    = 4'd2;
   localparam logic [3:0] PKT_ACK     = 4'd3;
   localparam logic [3:0] PKT_BACK    = 4'd4;
   localparam logic [3:0] PKT_QUERY   = 4'd5;
   localparam logic [3:0] PKT_NODEID  = 4'd6;
   localparam logic [3:0] PKT_CONFIG  = 4'd7;
   localparam logic [3:0] PKT_PING    = 4'd8;
   localparam logic [3:0] PKT_START   = 4'd9;
   localparam logic [3:0] PKT_HUSH    = 4'd10;
   localparam logic [3:0] PKT_RESEND  = 4'd11;
   localparam logic [3:0] PKT_END     = 4'd12;

   localparam logic [7:0] NODE_BOUND_RESET  = 8'd255;
   localparam logic [7:0] FIELD_LIMIT_RESET = 8'd64;
   localparam logic [6:0] CHAR_MASK         = 7'h7F;

   // letter position within its case group selects the type
   function automatic logic [3:0] type_lookup(input logic [4:0] pos);
      logic [3:0] t;
      unique case (pos)
         5'd1:    t = PKT_ACK;
         5'd2:    t = PKT_BACK;
         5'd3:    t = PKT_CONFIG;
         5'd4:    t = PKT_DATA;
         5'd5:    t = PKT_END;
         5'd8:    t = PKT_HUSH;
         5'd14:   t = PKT_NODEID;
         5'd16:   t = PKT_PING;
         5'd17:   t = PKT_QUERY;
         5'd18:   t = PKT_RESEND;
         5'd19:   t = PKT_START;
         5'd20:   t = PKT_TALK;
         default: t = PKT_INVALID;
      endcase
      return t;
   endfunction

endpackage

// File: rtl/core/ascii_packet_header_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_packet_header_parser_core
// parses an ascii packet header and streams its payload, one character a request
// ----------------------------------------------------------------------------
// usage
//   req channel: one request per received character (kind 0) or per receive
//   timeout tick (kind 1); bit 7 of rx_byte is ignored
//   rsp channel: exactly one status result per request, in order, with the
//   payload character, packet completion, last node numbers, packet type and
//   any error raised by that request
//   csr channel: index 0 node_bound, index 1 field_limit; always ready, write
//   only while no request is in flight
//   path: an accepted request is held in the input register, then stepped
//   through the parser into the result register once that register can take
//   it; throughput is one request per cycle while rsp_ready keeps up, set by
//   the loop through the parser state registers
//   reset: parser returns to listen, node and type registers clear, node_bound
//   goes to 255 and field_limit to 64
//   stall: while rsp_ready is low the result register holds and the input
//   register takes one more request before req_ready drops
// ----------------------------------------------------------------------------
module ascii_packet_header_parser_core
   import apph_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_wdata
);

   req_type    in_ff;
   logic       in_valid_ff;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;
   cls_type    char_cls;
   rsp_type    rsp_next;
   csr_wr_type csr_wr;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   apph_classify u_classify (
      .char_code (in_ff.rx_byte[6:0]),
      .char_cls  (char_cls)
   );

   apph_step u_step (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_wr),
      .step_valid (advance),
      .kind       (in_ff.kind),
      .char_code  (in_ff.rx_byte[6:0]),
      .char_cls   (char_cls),
      .rsp_next   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_req_loaded: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted request not held in input register");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled request lost from input register");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no result");

   a_pv_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.payload_valid |->
         !rsp_ff.error_valid && !rsp_ff.packet_done)
      else $error("payload byte flagged together with error or done");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.error_valid |-> rsp_ff.error_code == ERR_OVERRUN)
      else $error("error code set without error");

endmodule

// File: rtl/core/apph_classify.sv
// ----------------------------------------------------------------------------
// apph_classify
// sorts a masked 7-bit character into its lexical class
// ----------------------------------------------------------------------------
module apph_classify
   import apph_pkg::*;
(
   input  logic [6:0] char_code,
   output cls_type    char_cls
);

   always_comb begin
      priority if (char_code == 7'h01 || char_code == 7'h21) begin
         char_cls = CLS_SOH;
      end else if (char_code == 7'h00 || char_code == 7'h0A || char_code == 7'h0D ||
                   char_code == 7'h3B) begin
         char_cls = CLS_EOS;
      end else if (char_code == 7'h09 || char_code == 7'h20) begin
         char_cls = CLS_WS;
      end else if (char_code >= 7'h30 && char_code <= 7'h39) begin
         char_cls = CLS_DIGIT;
      end else if ((char_code >= 7'h41 && char_code <= 7'h5A) ||
                   (char_code >= 7'h61 && char_code <= 7'h7A)) begin
         char_cls = CLS_ALPHA;
      end else if (char_code == 7'h3D) begin
         char_cls = CLS_EQUAL;
      end else begin
         char_cls = CLS_JUNK;
      end
   end

endmodule

// File: rtl/core/apph_step.sv
// ----------------------------------------------------------------------------
// apph_step
// parser state, configuration registers and the per-character table step
// ----------------------------------------------------------------------------
module apph_step
   import apph_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  csr_wr_type csr_wr,
   input  logic       step_valid,
   input  logic       kind,
   input  logic [6:0] char_code,
   input  cls_type    char_cls,
   output rsp_type    rsp_next
);

   logic [7:0] node_bound_ff, field_limit_ff;
   state_type  st_ff, st_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [7:0] acc_ff, acc_in;
   logic [6:0] tch_ff, tch_in;
   logic [7:0] from_ff, from_in;
   logic [7:0] to_ff, to_in;
   logic [7:0] talker_ff, talker_in;
   logic [3:0] typ_ff, typ_in;

   logic [7:0]   sv_cnt;
   logic         sv_over;
   logic [11:0]  sv_prod;
   logic [7:0]   sv_acc;
   logic [3:0]   lookup;
   logic         save, err, pv, done;
   state_type    save_st;
   err_code_type code;

   // save-character arithmetic
   assign sv_cnt  = (cnt_ff == 8'd255) ? cnt_ff : cnt_ff + 8'd1;
   assign sv_over = sv_cnt > field_limit_ff;
   assign sv_prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                    {8'd0, char_code[3:0]};
   assign sv_acc  = (sv_prod > 12'd255) ? 8'd255 : sv_prod[7:0];
   assign lookup  = type_lookup(tch_ff[4:0]);

   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      tch_in    = tch_ff;
      from_in   = from_ff;
      to_in     = to_ff;
      talker_in = talker_ff;
      typ_in    = typ_ff;
      save      = 1'b0;
      save_st   = ST_LISTEN;
      err       = 1'b0;
      code      = ERR_OVERRUN;
      pv        = 1'b0;
      done      = 1'b0;
      if (kind) begin
         if (st_ff != ST_LISTEN) begin
            err  = 1'b1;
            code = ERR_TIMEOUT;
         end
      end else if (char_cls == CLS_SOH && st_ff != ST_PAYLOAD) begin
         cnt_in = 8'd0;
         acc_in = 8'd0;
         tch_in = 7'd0;
         st_in  = ST_START;
      end else begin
         unique case (st_ff)
            ST_LISTEN: begin
               st_in = ST_LISTEN;
            end
            ST_START: begin
               if (char_cls == CLS_DIGIT) begin
                  save = 1'b1; save_st = ST_FROM;
               end else if (char_cls == CLS_ALPHA) begin
                  save = 1'b1; save_st = ST_TYPE;
               end else if (char_cls != CLS_WS) begin
                  err = 1'b1; code = ERR_BAD_START;
               end
            end
            ST_FROM: begin
               if (char_cls == CLS_DIGIT) begin
                  save = 1'b1; save_st = ST_FROM;
               end else if (char_cls == CLS_WS) begin
                  if (acc_ff >= node_bound_ff) begin
                     err = 1'b1; code = ERR_INV_FROM;
                  end else begin
                     from_in = acc_ff;
                     cnt_in = 8'd0; acc_in = 8'd0; tch_in = 7'd0;
                     st_in = ST_ENDFROM;
                  end
               end else begin
                  err = 1'b1; code = ERR_BAD_FROM;
               end
            end
            ST_ENDFROM: begin
               if (char_cls == CLS_DIGIT) begin
                  save = 1'b1; save_st = ST_TO;
               end else if (char_cls != CLS_WS) begin
                  err = 1'b1; code = ERR_BAD_TO;
               end
            end
            ST_TO: begin
               if (char_cls == CLS_DIGIT) begin
                  save = 1'b1; save_st = ST_TO;
               end else if (char_cls == CLS_WS) begin
                  if (acc_ff >= node_bound_ff) begin
                     err = 1'b1; code = ERR_INV_TO;
                  end else begin
                     to_in = acc_ff;
                     cnt_in = 8'd0; acc_in = 8'd0; tch_in = 7'd0;
                     st_in = ST_ENDTO;
                  end
               end else begin
                  err = 1'b1; code = ERR_BAD_TO;
               end
            end
            ST_ENDTO: begin
               if (char_cls == CLS_DIGIT) begin
                  save = 1'b1; save_st = ST_NEXT;
               end else if (char_cls == CLS_ALPHA) begin
                  save = 1'b1; save_st = ST_TYPE;
               end else if (char_cls != CLS_WS) begin
                  err = 1'b1; code = ERR_BAD_NEXT;
               end
            end
            ST_NEXT: begin
               if (char_cls == CLS_DIGIT) begin
                  save = 1'b1; save_st = ST_NEXT;
               end else if (char_cls == CLS_WS) begin
                  if (acc_ff >= node_bound_ff) begin
                     err = 1'b1; code = ERR_INV_NEXT;
                  end else begin
                     talker_in = acc_ff;
                     cnt_in = 8'd0; acc_in = 8'd0; tch_in = 7'd0;
                     st_in = ST_ENDNEXT;
                  end
               end else begin
                  err = 1'b1; code = ERR_BAD_NEXT;
               end
            end
            ST_ENDNEXT: begin
               if (char_cls == CLS_ALPHA) begin
                  save = 1'b1; save_st = ST_TYPE;
               end else if (char_cls != CLS_WS) begin
                  err = 1'b1; code = ERR_BAD_TYPE;
               end
            end
            ST_TYPE: begin
               if (char_cls == CLS_ALPHA) begin
                  save = 1'b1; save_st = ST_TYPE;
               end else if (char_cls == CLS_EQUAL || char_cls == CLS_WS) begin
                  typ_in = lookup;
                  if (lookup == PKT_INVALID) begin
                     err = 1'b1; code = ERR_INV_TYPE;
                  end else begin
                     cnt_in = 8'd0; acc_in = 8'd0; tch_in = 7'd0;
                     st_in = (char_cls == CLS_EQUAL) ? ST_VALUE : ST_PAYLOAD;
                  end
               end else begin
                  err = 1'b1; code = ERR_BAD_TYPE;
               end
            end
            ST_VALUE: begin
               if (char_cls == CLS_DIGIT || char_cls == CLS_ALPHA) begin
                  save = 1'b1; save_st = ST_VALUE;
               end else if (char_cls == CLS_WS) begin
                  cnt_in = 8'd0; acc_in = 8'd0; tch_in = 7'd0;
                  st_in = ST_PAYLOAD;
               end else begin
                  err = 1'b1; code = ERR_BAD_VALUE;
               end
            end
            ST_PAYLOAD: begin
               if (char_cls == CLS_EOS) begin
                  done  = 1'b1;
                  st_in = ST_LISTEN;
               end else begin
                  save = 1'b1; save_st = ST_PAYLOAD;
               end
            end
            default: begin
               st_in = ST_LISTEN;
            end
         endcase
      end
      if (save) begin
         cnt_in = sv_cnt;
         if (sv_over) begin
            err  = 1'b1;
            code = ERR_OVERRUN;
         end else begin
            if (sv_cnt == 8'd1) begin
               tch_in = char_code;
            end
            if (char_cls == CLS_DIGIT) begin
               acc_in = sv_acc;
            end
            st_in = save_st;
            pv    = (st_ff == ST_PAYLOAD);
         end
      end
      if (err) begin
         st_in = ST_LISTEN;
      end
   end

   always_comb begin
      rsp_next.payload_valid = pv;
      rsp_next.payload_byte  = pv ? (char_code & CHAR_MASK) : 7'd0;
      rsp_next.packet_done   = done;
      rsp_next.from_node     = from_in;
      rsp_next.to_node       = to_in;
      rsp_next.next_talker   = talker_in;
      rsp_next.packet_type   = typ_in;
      rsp_next.error_valid   = err;
      rsp_next.error_code    = err ? code : ERR_OVERRUN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_bound_ff  <= NODE_BOUND_RESET;
         field_limit_ff <= FIELD_LIMIT_RESET;
      end else if (csr_wr.valid) begin
         unique case (csr_wr.index)
            CSR_NODE_BOUND:  node_bound_ff  <= csr_wr.data;
            CSR_FIELD_LIMIT: field_limit_ff <= csr_wr.data;
            default:         node_bound_ff  <= node_bound_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_LISTEN;
         cnt_ff    <= 8'd0;
         acc_ff    <= 8'd0;
         tch_ff    <= 7'd0;
         from_ff   <= 8'd0;
         to_ff     <= 8'd0;
         talker_ff <= 8'd0;
         typ_ff    <= PKT_INVALID;
      end else if (step_valid) begin
         st_ff     <= st_in;
         cnt_ff    <= cnt_in;
         acc_ff    <= acc_in;
         tch_ff    <= tch_in;
         from_ff   <= from_in;
         to_ff     <= to_in;
         talker_ff <= talker_in;
         typ_ff    <= typ_in;
      end
   end

endmodule

// File: tb/tb_ascii_packet_header_parser_core.sv
// ----------------------------------------------------------------------------
// tb_ascii_packet_header_parser_core
// self-checking bench for the ascii packet header parser: directed frames hit
// restarts, value fields, number saturation, bad nodes and types, timeouts and
// overrun, then random frames (clean, truncated, corrupted and noise) run under
// several node_bound / field_limit settings and idle patterns; every status is
// compared field by field against a cycle-free parser model kept in the bench
// ----------------------------------------------------------------------------
module tb_ascii_packet_header_parser_core;
   import apph_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_PRINTS   = 20;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_payload;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_payload;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [7:0]    csr_wdata;

   ascii_packet_header_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // parser model state and configuration
   state_type    m_state;
   logic [7:0]   m_count;
   logic [7:0]   m_accum;
   logic [6:0]   m_type_char;
   logic [7:0]   m_from;
   logic [7:0]   m_to;
   logic [7:0]   m_talker;
   logic [3:0]   m_type;
   logic         m_err;
   err_code_type m_err_code;
   logic [7:0]   cfg_node_bound;
   logic [7:0]   cfg_field_limit;

   rsp_type expected_status[$];
   req_type frame_q[$];
   rsp_type want;
   rsp_type got;

   int send_idle_pct;
   int recv_stall_pct;
   int cycle_count;
   int mismatches;
   int requests_sent;
   int useful_items;
   int statuses_checked;
   int packets_done;
   int errors_seen;
   int payload_chars;

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("error: run exceeded %0d cycles, %0d statuses outstanding",
                  CYCLE_LIMIT, expected_status.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] actual,
                                  input logic [31:0] expected);
      if (mismatches < MAX_PRINTS) begin
         $display("mismatch at status %0d: %s is %0d, expected %0d",
                  statuses_checked, field, actual, expected);
      end
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------------
   function automatic cls_type char_class(input logic [6:0] c);
      if (c == 7'h01 || c == 7'h21) return CLS_SOH;
      if (c == 7'h00 || c == 7'h0A || c == 7'h0D || c == 7'h3B) return CLS_EOS;
      if (c == 7'h09 || c == 7'h20) return CLS_WS;
      if (c >= 7'h30 && c <= 7'h39) return CLS_DIGIT;
      if ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A)) return CLS_ALPHA;
      if (c == 7'h3D) return CLS_EQUAL;
      return CLS_JUNK;
   endfunction

   // case-insensitive one-letter packet type
   function automatic logic [3:0] type_of_letter(input logic [6:0] c);
      case ({1'b0, c | 7'h20})
         "a":     return PKT_ACK;
         "b":     return PKT_BACK;
         "c":     return PKT_CONFIG;
         "d":     return PKT_DATA;
         "e":     return PKT_END;
         "h":     return PKT_HUSH;
         "n":     return PKT_NODEID;
         "p":     return PKT_PING;
         "q":     return PKT_QUERY;
         "r":     return PKT_RESEND;
         "s":     return PKT_START;
         "t":     return PKT_TALK;
         default: return PKT_INVALID;
      endcase
   endfunction

   function automatic void reset_parser_model();
      m_state = ST_LISTEN;
      m_count = '0;
      m_accum = '0;
      m_type_char = '0;
      m_from = '0;
      m_to = '0;
      m_talker = '0;
      m_type = PKT_INVALID;
      cfg_node_bound = NODE_BOUND_RESET;
      cfg_field_limit = FIELD_LIMIT_RESET;
   endfunction

   function automatic void drop_to_listen(input err_code_type code);
      m_err = 1'b1;
      m_err_code = code;
      m_state = ST_LISTEN;
   endfunction

   function automatic void clear_field();
      m_count = '0;
      m_accum = '0;
      m_type_char = '0;
   endfunction

   function automatic bit take_char(input logic [6:0] c, input cls_type cl);
      int v;
      if (m_count != 8'hFF) m_count = m_count + 8'd1;
      if (m_count > cfg_field_limit) begin
         drop_to_listen(ERR_OVERRUN);
         return 1'b0;
      end
      if (m_count == 8'd1) m_type_char = c;
      if (cl == CLS_DIGIT) begin
         v = int'(m_accum) * 10 + int'(c) - int'("0");
         m_accum = (v > 255) ? 8'hFF : 8'(v);
      end
      return 1'b1;
   endfunction

   function automatic bit node_fits(input err_code_type code);
      if (m_accum >= cfg_node_bound) begin
         drop_to_listen(code);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void close_type(input state_type nxt);
      m_type = type_of_letter(m_type_char);
      if (m_type == PKT_INVALID) begin
         drop_to_listen(ERR_INV_TYPE);
      end else begin
         clear_field();
         m_state = nxt;
      end
   endfunction

   task automatic parse_char(input req_type r, output rsp_type o);
      logic [6:0] c;
      cls_type    cl;
      bit         pv;
      bit         done;
      c = r.rx_byte[6:0];
      cl = char_class(c);
      pv = 1'b0;
      done = 1'b0;
      m_err = 1'b0;
      m_err_code = ERR_OVERRUN;  // zero when no error
      if (r.kind) begin
         if (m_state != ST_LISTEN) drop_to_listen(ERR_TIMEOUT);
      end else if (cl == CLS_SOH && m_state != ST_PAYLOAD) begin
         clear_field();
         m_state = ST_START;
      end else begin
         case (m_state)
            ST_START: begin
               if (cl == CLS_DIGIT) begin
                  if (take_char(c, cl)) m_state = ST_FROM;
               end else if (cl == CLS_ALPHA) begin
                  if (take_char(c, cl)) m_state = ST_TYPE;
               end else if (cl != CLS_WS) begin
                  drop_to_listen(ERR_BAD_START);
               end
            end
            ST_FROM: begin
               if (cl == CLS_DIGIT) begin
                  void'(take_char(c, cl));
               end else if (cl == CLS_WS) begin
                  if (node_fits(ERR_INV_FROM)) begin
                     m_from = m_accum;
                     clear_field();
                     m_state = ST_ENDFROM;
                  end
               end else begin
                  drop_to_listen(ERR_BAD_FROM);
               end
            end
            ST_ENDFROM: begin
               if (cl == CLS_DIGIT) begin
                  if (take_char(c, cl)) m_state = ST_TO;
               end else if (cl != CLS_WS) begin
                  drop_to_listen(ERR_BAD_TO);
               end
            end
            ST_TO: begin
               if (cl == CLS_DIGIT) begin
                  void'(take_char(c, cl));
               end else if (cl == CLS_WS) begin
                  if (node_fits(ERR_INV_TO)) begin
                     m_to = m_accum;
                     clear_field();
                     m_state = ST_ENDTO;
                  end
               end else begin
                  drop_to_listen(ERR_BAD_TO);
               end
            end
            ST_ENDTO: begin
               if (cl == CLS_DIGIT) begin
                  if (take_char(c, cl)) m_state = ST_NEXT;
               end else if (cl == CLS_ALPHA) begin
                  if (take_char(c, cl)) m_state = ST_TYPE;
               end else if (cl != CLS_WS) begin
                  drop_to_listen(ERR_BAD_NEXT);
               end
            end
            ST_NEXT: begin
               if (cl == CLS_DIGIT) begin
                  void'(take_char(c, cl));
               end else if (cl == CLS_WS) begin
                  if (node_fits(ERR_INV_NEXT)) begin
                     m_talker = m_accum;
                     clear_field();
                     m_state = ST_ENDNEXT;
                  end
               end else begin
                  drop_to_listen(ERR_BAD_NEXT);
               end
            end
            ST_ENDNEXT: begin
               if (cl == CLS_ALPHA) begin
                  if (take_char(c, cl)) m_state = ST_TYPE;
               end else if (cl != CLS_WS) begin
                  drop_to_listen(ERR_BAD_TYPE);
               end
            end
            ST_TYPE: begin
               if (cl == CLS_ALPHA) void'(take_char(c, cl));
               else if (cl == CLS_EQUAL) close_type(ST_VALUE);
               else if (cl == CLS_WS) close_type(ST_PAYLOAD);
               else drop_to_listen(ERR_BAD_TYPE);
            end
            ST_VALUE: begin
               if (cl == CLS_DIGIT || cl == CLS_ALPHA) begin
                  void'(take_char(c, cl));
               end else if (cl == CLS_WS) begin
                  clear_field();
                  m_state = ST_PAYLOAD;
               end else begin
                  drop_to_listen(ERR_BAD_VALUE);
               end
            end
            ST_PAYLOAD: begin
               if (cl == CLS_EOS) begin
                  done = 1'b1;
                  m_state = ST_LISTEN;
               end else if (take_char(c, cl)) begin
                  pv = 1'b1;
               end
            end
            default: m_state = ST_LISTEN;
         endcase
      end
      o.payload_valid = pv;
      o.payload_byte = pv ? c : 7'd0;
      o.packet_done = done;
      o.from_node = m_from;
      o.to_node = m_to;
      o.next_talker = m_talker;
      o.packet_type = m_type;
      o.error_valid = m_err;
      o.error_code = m_err_code;
   endtask

   // ------------------------------------------------------------------------
   // status checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("status with nothing pending", 1, 0);
         end else begin
            want = expected_status.pop_front();
            got = rsp_payload;
            if (got.payload_valid !== want.payload_valid)
               report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
            if (got.payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
            if (got.packet_done !== want.packet_done)
               report_mismatch("packet_done", got.packet_done, want.packet_done);
            if (got.from_node !== want.from_node)
               report_mismatch("from_node", got.from_node, want.from_node);
            if (got.to_node !== want.to_node)
               report_mismatch("to_node", got.to_node, want.to_node);
            if (got.next_talker !== want.next_talker)
               report_mismatch("next_talker", got.next_talker, want.next_talker);
            if (got.packet_type !== want.packet_type)
               report_mismatch("packet_type", got.packet_type, want.packet_type);
            if (got.error_valid !== want.error_valid)
               report_mismatch("error_valid", got.error_valid, want.error_valid);
            if (got.error_code !== want.error_code)
               report_mismatch("error_code", got.error_code, want.error_code);
            statuses_checked++;
            if (want.packet_done) packets_done++;
            if (want.error_valid) errors_seen++;
            if (want.payload_valid) payload_chars++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_request(input req_type r);
      rsp_type   predicted;
      state_type was;
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      was = m_state;
      parse_char(r, predicted);
      expected_status.push_back(predicted);
      requests_sent++;
      if (was != ST_LISTEN || m_state != ST_LISTEN) useful_items++;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type r;
      r.kind = 1'b0;
      r.rx_byte = b;
      send_request(r);
   endtask

   task automatic send_tick(input logic [7:0] b);
      req_type r;
      r.kind = 1'b1;
      r.rx_byte = b;
      send_request(r);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // wait for every pending status, then let the pipeline go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_NODE_BOUND) cfg_node_bound = val;
      else cfg_field_limit = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(input logic [7:0] node_bound, input logic [7:0] field_limit);
      settle();
      write_csr(CSR_NODE_BOUND, node_bound);
      write_csr(CSR_FIELD_LIMIT, field_limit);
   endtask

   // ------------------------------------------------------------------------
   // random frame builder
   // ------------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b);
      req_type r;
      r.kind = 1'b0;
      r.rx_byte = b | (($urandom_range(7) == 0) ? 8'h80 : 8'h00);
      frame_q.push_back(r);
   endfunction

   function automatic void add_tick();
      req_type r;
      r.kind = 1'b1;
      r.rx_byte = 8'($urandom);
      frame_q.push_back(r);
   endfunction

   function automatic void add_ws();
      if ($urandom_range(1)) add_byte(" ");
      else add_byte(8'h09);
      if ($urandom_range(7) == 0) add_byte(" ");
   endfunction

   function automatic void add_number(input int n);
      string s;
      int    i;
      s = $sformatf("%0d", n);
      if ($urandom_range(9) == 0) add_byte("0");
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic int pick_node();
      int p;
      p = $urandom_range(99);
      if (p < 75) return $urandom_range(int'(cfg_node_bound) - 1, 0);
      if (p < 93) return $urandom_range(255, 0);
      return $urandom_range(99999, 256);
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] ch;
      ch = 8'($urandom_range(8'h7A, 8'h61));
      if ($urandom_range(1)) ch = ch & 8'hDF;
      return ch;
   endfunction

   function automatic logic [7:0] pick_type_letter();
      string      letters;
      logic [7:0] ch;
      letters = "abcdehnpqrst";
      if ($urandom_range(9) == 0) return rand_letter();
      ch = letters[$urandom_range(11)];
      if ($urandom_range(1)) ch = ch & 8'hDF;
      return ch;
   endfunction

   function automatic logic [7:0] pick_payload_char();
      logic [7:0] ch;
      do ch = 8'($urandom); while (char_class(ch[6:0]) == CLS_EOS);
      return ch;
   endfunction

   function automatic logic [7:0] pick_end_char();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'h0A;
         2:       return 8'h0D;
         default: return ";";
      endcase
   endfunction

   task automatic random_frame();
      int shape;
      int n;
      int p;
      int i;
      int cut;
      frame_q.delete();
      shape = $urandom_range(99);
      if (shape < 15) begin
         n = $urandom_range(8, 1);
         repeat (n) begin
            if ($urandom_range(4) == 0) add_tick();
            else add_byte(8'($urandom));
         end
      end else begin
         add_byte($urandom_range(1) ? "!" : 8'h01);
         if ($urandom_range(5) == 0) add_ws();
         if ($urandom_range(9) != 0) begin
            add_number(pick_node());
            add_ws();
            add_number(pick_node());
            add_ws();
            if ($urandom_range(2) == 0) begin
               add_number(pick_node());
               add_ws();
            end
         end
         add_byte(pick_type_letter());
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(3, 1);
            repeat (n) add_byte(rand_letter());
         end
         if ($urandom_range(3) == 0) begin
            add_byte("=");
            n = $urandom_range(3);
            repeat (n) add_byte($urandom_range(1) ? rand_letter()
                                                  : 8'($urandom_range(8'h39, 8'h30)));
         end
         add_ws();
         p = $urandom_range(99);
         if (p < 10) n = 0;
         else if (p < 95) n = $urandom_range(6, 1);
         else if (cfg_field_limit < 70) n = int'(cfg_field_limit) + $urandom_range(1);
         else n = $urandom_range(70, 20);
         repeat (n) add_byte(pick_payload_char());
         add_byte(pick_end_char());
         // truncated frames, some closed by a timeout
         if (shape < 30) begin
            cut = $urandom_range(frame_q.size() - 1, 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
            if ($urandom_range(1)) add_tick();
         end
         // light corruption of the built frames, truncated or not
         for (i = 1; i < frame_q.size(); i++) begin
            p = $urandom_range(99);
            if (p < 2) frame_q[i].rx_byte = 8'($urandom);
            else if (p < 3) frame_q[i].kind = 1'b1;
         end
      end
      foreach (frame_q[j]) send_request(frame_q[j]);
   endtask

   task automatic run_random(input int target);
      int start_count;
      start_count = requests_sent;
      while (requests_sent - start_count < target) random_frame();
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_frames();
      set_idle(0, 0);
      send_tick(8'hFF);             // timeout while listening
      send_byte(8'h81);             // start with bit 7 set
      send_text("dx=Z ");           // type right after start, extra letter, value
      send_byte("!");               // start char inside payload is data
      send_byte(8'hBB);             // end char with bit 7 set
      send_text("!300 ");           // saturated number, invalid from node
      send_text("!1 2 3 F ");       // next talker then invalid type
      send_text("!");
      send_tick(8'h00);             // timeout mid packet
   endtask

   task automatic test_field_overrun();
      set_limits(8'd255, 8'd1);
      send_text("!12");
      send_text("!0 0 t xy;");
   endtask

   task automatic test_free_flow();
      set_idle(0, 0);
      set_limits(8'd255, 8'd64);
      run_random(180);
      set_limits(8'd1, 8'd255);
      run_random(180);
   endtask

   task automatic test_sender_gaps();
      set_idle(87, 0);
      set_limits(8'd128, 8'd8);
      run_random(360);
   endtask

   task automatic test_receiver_stalls();
      set_idle(0, 87);
      set_limits(8'd1, 8'd1);
      run_random(180);
      set_limits(8'd255, 8'd255);
      run_random(180);
   endtask

   task automatic test_both_idle();
      set_idle(32, 32);
      repeat (3) begin
         set_limits(8'($urandom_range(255, 1)), 8'($urandom_range(24, 1)));
         run_random(120);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_NODE_BOUND;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      cycle_count = 0;
      mismatches = 0;
      requests_sent = 0;
      useful_items = 0;
      statuses_checked = 0;
      packets_done = 0;
      errors_seen = 0;
      payload_chars = 0;
      reset_parser_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_field_overrun();
      test_free_flow();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();

      settle();
      repeat (8) @(posedge clock);
      $display("covered %0d requests (%0d past listen) in %0d cycles, %0d statuses checked",
               requests_sent, useful_items, cycle_count, statuses_checked);
      $display("%0d packets completed, %0d parse errors, %0d payload characters, %0d mismatches",
               packets_done, errors_seen, payload_chars, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
